// ----- hdl/tglc_pkg.sv -----
package tglc_pkg;

  localparam int NIB_W  = 4;
  localparam int MASK_W = 8;
  localparam int CNT_W  = 9;
  localparam int WAL_W  = 6;
  localparam int COR_W  = 11;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  typedef logic [NIB_W-1:0] nib_t;
  typedef logic signed [WAL_W-1:0] walsh_t;
  typedef walsh_t walsh_tab_t [256];

  typedef struct packed {
    walsh_t lo;
    walsh_t hi;
  } walsh_pair_t;

  localparam nib_t SBOX [16] = '{
    4'd1, 4'd10, 4'd4, 4'd12, 4'd6, 4'd15, 4'd3, 4'd9,
    4'd2, 4'd13, 4'd11, 4'd7, 4'd5, 4'd0, 4'd8, 4'd14
  };

  localparam logic [2:0] BIT_DEST [8] = '{
    3'd0, 3'd3, 3'd5, 3'd7, 3'd2, 3'd4, 3'd6, 3'd1
  };

  // Walsh value of the 4-bit S-box, indexed by {input mask, output mask}.
  // It is the number of agreeing minus disagreeing parities over 16 inputs.
  function automatic walsh_tab_t build_walsh_tab();
    walsh_tab_t tab;
    int         acc;
    nib_t       xv;
    nib_t       sx;
    for (int a = 0; a < 16; a++) begin
      for (int b = 0; b < 16; b++) begin
        acc = 0;
        for (int x = 0; x < 16; x++) begin
          xv = nib_t'(x);
          sx = SBOX[xv];
          if (^((nib_t'(a) & xv) ^ (nib_t'(b) & sx))) begin
            acc = acc - 1;
          end else begin
            acc = acc + 1;
          end
        end
        tab[{nib_t'(a), nib_t'(b)}] = walsh_t'(acc);
      end
    end
    return tab;
  endfunction

  localparam walsh_tab_t WALSH_TAB = build_walsh_tab();

endpackage

// ----- hdl/toy_gift_linear_correlation_top.sv -----
// An accepted request is registered in walsh_r, then its result in res_r.
// Throughput: one request per cycle while the output is not stalled; the nibble
// Walsh lookup and the product that combines the two nibbles each sit in
// their own stage. While the result waits on out_tready an empty first
// stage still takes one request, and after that both stages hold.
// Reset (rst_n low, synchronous) empties both stages; no other state exists.
module toy_gift_linear_correlation_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // input_mask[7:0], output_mask[15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // zero_count[8:0], one_count[17:9],
                                  // abs_difference[26:18], zero fill
);

  tglc_pkg::walsh_pair_t walsh_nxt;
  tglc_pkg::walsh_pair_t walsh_r;
  logic                  stg_v_r;
  logic                  out_v_r;
  logic [8:0]            zero_nxt;
  logic [8:0]            one_nxt;
  logic [8:0]            abs_nxt;
  logic [26:0]           res_r;
  logic                  advance;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !stg_v_r || advance;

  tglc_walsh u_walsh (
    .input_mask  (in_tdata[7:0]),
    .output_mask (in_tdata[15:8]),
    .walsh       (walsh_nxt)
  );

  tglc_result u_result (
    .walsh          (walsh_r),
    .zero_count     (zero_nxt),
    .one_count      (one_nxt),
    .abs_difference (abs_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        stg_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= stg_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      walsh_r <= walsh_nxt;
    end
    if (advance && stg_v_r) begin
      res_r <= {abs_nxt, one_nxt, zero_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, res_r};

  // The two counts always cover all 256 inputs.
  a_count_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (10'(out_tdata[8:0]) + 10'(out_tdata[17:9]) == 10'd256))
    else $error("zero and one counts do not sum to 256");

  // A product of two even Walsh values is a multiple of four.
  a_abs_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:18] == 2'b00))
    else $error("bias magnitude is not a multiple of four");

  a_abs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[8:0] >= out_tdata[17:9]) ?
      (out_tdata[26:18] == out_tdata[8:0] - out_tdata[17:9]) :
      (out_tdata[26:18] == out_tdata[17:9] - out_tdata[8:0])))
    else $error("bias magnitude does not match the counts");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> stg_v_r)
    else $error("accepted request was dropped from the first stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v_r && !advance) |=> (stg_v_r && $stable(walsh_r)))
    else $error("stalled first stage lost its contents");

endmodule

// ----- hdl/tglc_walsh.sv -----
module tglc_walsh (
  input  logic [7:0]           input_mask,
  input  logic [7:0]           output_mask,
  output tglc_pkg::walsh_pair_t walsh
);

  logic [7:0] pre_perm_mask;

  // The output mask is carried back through the bit permutation, so the
  // parity splits into one term for each nibble of the S-box layer.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pre_perm_mask[i] = output_mask[tglc_pkg::BIT_DEST[i]];
    end
  end

  assign walsh.lo = tglc_pkg::WALSH_TAB[{input_mask[3:0], pre_perm_mask[3:0]}];
  assign walsh.hi = tglc_pkg::WALSH_TAB[{input_mask[7:4], pre_perm_mask[7:4]}];

endmodule

// ----- hdl/tglc_result.sv -----
module tglc_result (
  input  tglc_pkg::walsh_pair_t walsh,
  output logic [8:0]            zero_count,
  output logic [8:0]            one_count,
  output logic [8:0]            abs_difference
);

  logic signed [tglc_pkg::COR_W-1:0] corr;
  logic signed [tglc_pkg::COR_W-1:0] zeros_x2;
  logic signed [tglc_pkg::COR_W-1:0] ones_x2;
  logic signed [tglc_pkg::COR_W-1:0] corr_abs;

  // The nibble terms are independent, so the total correlation over all
  // 256 inputs is the product of the two nibble Walsh values.
  assign corr     = tglc_pkg::COR_W'(walsh.lo) * tglc_pkg::COR_W'(walsh.hi);
  assign zeros_x2 = tglc_pkg::COR_W'(256) + corr;
  assign ones_x2  = tglc_pkg::COR_W'(256) - corr;
  assign corr_abs = corr[tglc_pkg::COR_W-1] ? -corr : corr;

  assign zero_count     = zeros_x2[9:1];
  assign one_count      = ones_x2[9:1];
  assign abs_difference = corr_abs[8:0];

endmodule

// ----- tb/tglc_lat_checker.sv -----
module tglc_lat_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tglc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output int                               fail_count,
  output int                               pending,
  output int                               checked,
  output int                               unbiased,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tglc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [tglc_pkg::MASK_W-1:0] in_mask;
    logic [tglc_pkg::MASK_W-1:0] out_mask;
    logic [tglc_pkg::CNT_W-1:0]  zeros;
    logic [tglc_pkg::CNT_W-1:0]  ones;
    logic [tglc_pkg::CNT_W-1:0]  bias;
  } lat_entry_t;

  localparam logic [3:0] NIB_SUB [16] = '{
    4'd1, 4'd10, 4'd4, 4'd12, 4'd6, 4'd15, 4'd3, 4'd9,
    4'd2, 4'd13, 4'd11, 4'd7, 4'd5, 4'd0, 4'd8, 4'd14
  };
  localparam int BIT_POS [8] = '{0, 3, 5, 7, 2, 4, 6, 1};

  lat_entry_t lat_q[$];

  // S-box on both nibbles, then the fixed bit shuffle.
  function automatic logic [tglc_pkg::MASK_W-1:0] gift_round_of(
    input logic [tglc_pkg::MASK_W-1:0] v
  );
    logic [tglc_pkg::MASK_W-1:0] s;
    logic [tglc_pkg::MASK_W-1:0] r;
    s = {NIB_SUB[v[7:4]], NIB_SUB[v[3:0]]};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[BIT_POS[i]] = s[i];
    end
    return r;
  endfunction

  function automatic lat_entry_t lat_entry(input logic [tglc_pkg::MASK_W-1:0] in_mask,
                                           input logic [tglc_pkg::MASK_W-1:0] out_mask);
    lat_entry_t e;
    int         zeros;
    int         ones;
    logic [tglc_pkg::MASK_W-1:0] xv;
    zeros = 0;
    ones  = 0;
    for (int x = 0; x < 256; x++) begin
      xv = tglc_pkg::MASK_W'(x);
      if (^((xv & in_mask) ^ (gift_round_of(xv) & out_mask))) begin
        ones++;
      end else begin
        zeros++;
      end
    end
    e.in_mask  = in_mask;
    e.out_mask = out_mask;
    e.zeros    = tglc_pkg::CNT_W'(zeros);
    e.ones     = tglc_pkg::CNT_W'(ones);
    e.bias     = tglc_pkg::CNT_W'(zeros >= ones ? zeros - ones : ones - zeros);
    return e;
  endfunction

  task automatic report(input string msg);
    fail_count++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    lat_entry_t want;
    logic [tglc_pkg::CNT_W-1:0] got_zeros;
    logic [tglc_pkg::CNT_W-1:0] got_ones;
    logic [tglc_pkg::CNT_W-1:0] got_bias;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_zeros = out_tdata[tglc_pkg::CNT_W-1:0];
        got_ones  = out_tdata[2*tglc_pkg::CNT_W-1:tglc_pkg::CNT_W];
        got_bias  = out_tdata[3*tglc_pkg::CNT_W-1:2*tglc_pkg::CNT_W];
        if (lat_q.size() == 0) begin
          report("result arrived with no request outstanding");
        end else begin
          want = lat_q.pop_front();
          if (got_zeros !== want.zeros) begin
            report($sformatf("masks %h/%h zero_count got %0d want %0d",
                             want.in_mask, want.out_mask, got_zeros, want.zeros));
          end
          if (got_ones !== want.ones) begin
            report($sformatf("masks %h/%h one_count got %0d want %0d",
                             want.in_mask, want.out_mask, got_ones, want.ones));
          end
          if (got_bias !== want.bias) begin
            report($sformatf("masks %h/%h abs_difference got %0d want %0d",
                             want.in_mask, want.out_mask, got_bias, want.bias));
          end
          checked <= checked + 1;
          if (want.bias == 0) begin
            unbiased <= unbiased + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        lat_q.push_back(lat_entry(in_tdata[tglc_pkg::MASK_W-1:0],
                                  in_tdata[2*tglc_pkg::MASK_W-1:tglc_pkg::MASK_W]));
      end
    end
    pending <= lat_q.size();
  end

endmodule

// ----- tb/toy_gift_linear_correlation_top_tb.sv -----
module toy_gift_linear_correlation_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT     = 400000;
  localparam int N_RANDOM  = 700;
  localparam int BLOCK_LEN = 100;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [tglc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tglc_pkg::OUT_TDATA_W-1:0] out_tdata;

  int   fail_count;
  int   pending;
  int   checked;
  int   unbiased;
  int   sent;
  int   cycles;
  int   stall_left;
  logic steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  toy_gift_linear_correlation_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tglc_lat_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .unbiased   (unbiased),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("toy_gift_linear_correlation_top test failed");
      $finish;
    end
  end

  // The valid line stays high into the next request when no gap is drawn.
  task automatic send_masks(input logic [tglc_pkg::MASK_W-1:0] am,
                            input logic [tglc_pkg::MASK_W-1:0] bm);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {bm, am};
    do @(posedge clk); while (!in_tready);
    sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= tglc_pkg::IN_TDATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [tglc_pkg::MASK_W-1:0] sparse_mask();
    logic [tglc_pkg::MASK_W-1:0] m;
    m = tglc_pkg::MASK_W'(1) << $urandom_range(0, 7);
    if ($urandom_range(0, 1) == 1) m = m | (tglc_pkg::MASK_W'(1) << $urandom_range(0, 7));
    return m;
  endfunction

  function automatic logic [tglc_pkg::MASK_W-1:0] nibble_mask();
    return tglc_pkg::MASK_W'($urandom_range(1, 15)) << (4 * $urandom_range(0, 1));
  endfunction

  initial begin
    logic [tglc_pkg::MASK_W-1:0] am;
    logic [tglc_pkg::MASK_W-1:0] bm;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    sent       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both masks zero gives the full 256 bias; then the extremes and patterns.
    send_masks(8'h00, 8'h00);
    send_masks(8'hFF, 8'hFF);
    send_masks(8'hFF, 8'h00);
    send_masks(8'h00, 8'hFF);
    send_masks(8'h0F, 8'hF0);
    send_masks(8'hF0, 8'h0F);
    send_masks(8'h55, 8'hAA);
    send_masks(8'hAA, 8'h55);
    for (int i = 0; i < 8; i++) begin
      send_masks(tglc_pkg::MASK_W'(1) << i, tglc_pkg::MASK_W'(1) << ((i * 3) % 8));
    end
    send_masks(8'h80, 8'h80);
    send_masks(8'h01, 8'h01);
    send_masks(8'h7F, 8'hFE);
    send_masks(8'hFE, 8'h7F);

    // Blocks alternate between random idling and back-to-back traffic.
    for (int n = 0; n < N_RANDOM; n++) begin
      steady <= ((n / BLOCK_LEN) % 2) == 1;
      case ($urandom_range(0, 9))
        5, 6: begin
          am = sparse_mask();
          bm = sparse_mask();
        end
        7: begin
          am = '0;
          bm = tglc_pkg::MASK_W'($urandom);
        end
        8: begin
          am = tglc_pkg::MASK_W'($urandom);
          bm = '0;
        end
        9: begin
          am = nibble_mask();
          bm = nibble_mask();
        end
        default: begin
          am = tglc_pkg::MASK_W'($urandom);
          bm = tglc_pkg::MASK_W'($urandom);
        end
      endcase
      send_masks(am, bm);
    end

    in_tvalid <= 1'b0;
    steady    <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d mask pairs, checked %0d table entries (%0d with zero bias).",
             sent, checked, unbiased);
    $display("Traffic mixed random idling and stalls with back-to-back stretches.");
    if (fail_count == 0) begin
      $display("toy_gift_linear_correlation_top test passed");
    end else begin
      $display("toy_gift_linear_correlation_top test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tglc_pkg.sv
hdl/tglc_walsh.sv
hdl/tglc_result.sv
hdl/toy_gift_linear_correlation_top.sv
tb/tglc_lat_checker.sv
tb/toy_gift_linear_correlation_top_tb.sv
